>>> rtl/b64d_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the stream decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned ACC_W       = 18;
    localparam int unsigned TRIPLE_W    = 24;
    localparam int unsigned COUNT_W     = 2;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0]   PAD_CHAR   = 8'h3D;
    localparam logic [SEXTET_W-1:0] SEXTET_62  = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_63  = 6'd63;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    localparam logic [COUNT_W-1:0] CNT_NONE  = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE   = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] CNT_THREE = 2'd3;

    // classified character as it travels from front to back
    typedef struct packed {
        logic [SEXTET_W-1:0] sextet;   // 0 when not in the alphabet
        logic                is_pad;
        logic                invalid;  // outside the alphabet, '=' included
        logic                last;
    } b64d_item_t;

    function automatic b64d_item_t b64d_classify(input logic [CHAR_W-1:0] ch,
                                                 input logic              last);
        b64d_item_t it;
        it.sextet  = '0;
        it.invalid = 1'b0;
        it.is_pad  = (ch == PAD_CHAR);
        it.last    = last;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            it.sextet = SEXTET_W'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A) begin
            it.sextet = SEXTET_W'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            it.sextet = SEXTET_W'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B) begin
            it.sextet = SEXTET_62;
        end
        else if (ch == 8'h2F) begin
            it.sextet = SEXTET_63;
        end
        else begin
            it.invalid = 1'b1;
        end
        return it;
    endfunction

endpackage
`default_nettype wire

>>> rtl/b64d_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_front
// Input stage: takes one character word and registers its classification.
// ---------------------------------------------------------------------------
module b64d_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] char_code
    input  wire logic                       s_tlast,   // last_char
    output logic                            item_valid,
    input  wire logic                       item_ready,
    output b64d_pkg::b64d_item_t            item
);
    import b64d_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    b64d_item_t item_reg;
    logic       take;

    assign s_tready = !vld_reg || item_ready;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (item_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= b64d_classify(s_tdata, s_tlast);
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

>>> rtl/b64d_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_queue
// Small first-in first-out buffer between the front and back stages.
// ---------------------------------------------------------------------------
module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire b64d_pkg::b64d_item_t wr_item,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output b64d_pkg::b64d_item_t     rd_item
);
    import b64d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64d_item_t    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          push;
    logic          pop;

    assign wr_ready = (cnt_reg != FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64d_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_back
// Quad assembly, padding and error tracking, with the registered output word.
// ---------------------------------------------------------------------------
module b64d_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire b64d_pkg::b64d_item_t item,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tlast,
    output logic [0:0]                m_tuser
);
    import b64d_pkg::*;

    logic [1:0]          pos_reg,  pos_next;
    logic [ACC_W-1:0]    acc_reg,  acc_next;
    logic                pat_reg,  pat_next;
    logic                pqd_reg,  pqd_next;
    logic                err_reg,  err_next;

    logic                ovld_reg, ovld_next;
    logic [TRIPLE_W-1:0] obytes_reg, obytes_next;
    logic [COUNT_W-1:0]  ocnt_reg, ocnt_next;
    logic                olast_reg, olast_next;
    logic                oerr_reg, oerr_next;

    logic                pop;
    logic [1:0]          pos_inc;
    logic [SEXTET_W-1:0] v;
    logic [COUNT_W-1:0]  cnt;
    logic [TRIPLE_W-1:0] triple;

    assign item_ready = !ovld_reg || m_tready;
    assign pop        = item_valid && item_ready;
    assign pos_inc    = pos_reg + 1'b1;

    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        pat_next    = pat_reg;
        pqd_next    = pqd_reg;
        err_next    = err_reg;
        ovld_next   = ovld_reg && !m_tready;
        obytes_next = obytes_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        v           = item.sextet;
        cnt         = CNT_NONE;
        triple      = '0;

        if (pop)
        begin
            // any character after a padded quad is an error
            err_next = err_reg || pqd_reg;
            unique case (pos_reg)
                POS_FIRST, POS_SECOND:
                begin
                    if (item.invalid)
                    begin
                        err_next = 1'b1;
                    end
                    acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], v};
                end
                POS_THIRD:
                begin
                    if (item.is_pad)
                    begin
                        pat_next = 1'b1;
                    end
                    else if (item.invalid)
                    begin
                        err_next = 1'b1;
                    end
                    acc_next = {acc_reg[ACC_W-SEXTET_W-1:0], v};
                end
                POS_FOURTH:
                begin
                    if (pat_reg)
                    begin
                        if (!item.is_pad)
                        begin
                            err_next = 1'b1;
                        end
                        cnt      = CNT_ONE;
                        pqd_next = 1'b1;
                        v        = '0;
                    end
                    else if (item.is_pad)
                    begin
                        cnt      = CNT_TWO;
                        pqd_next = 1'b1;
                    end
                    else if (item.invalid)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cnt = CNT_THREE;
                    end
                    triple   = {acc_reg, v};
                    acc_next = '0;
                    pat_next = 1'b0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            pos_next = pos_inc;

            // message ending inside a quad
            if (item.last && pos_inc != POS_FIRST)
            begin
                err_next = 1'b1;
            end
            if (err_next)
            begin
                cnt = CNT_NONE;
            end

            ovld_next   = 1'b1;
            ocnt_next   = cnt;
            olast_next  = item.last;
            oerr_next   = item.last && err_next;
            obytes_next[7:0]   = (cnt >= CNT_ONE)   ? triple[23:16] : 8'h00;
            obytes_next[15:8]  = (cnt >= CNT_TWO)   ? triple[15:8]  : 8'h00;
            obytes_next[23:16] = (cnt >= CNT_THREE) ? triple[7:0]   : 8'h00;

            if (item.last)
            begin
                pos_next = POS_FIRST;
                acc_next = '0;
                pat_next = 1'b0;
                pqd_next = 1'b0;
                err_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_FIRST;
            acc_reg  <= '0;
            pat_reg  <= 1'b0;
            pqd_reg  <= 1'b0;
            err_reg  <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            pat_reg  <= pat_next;
            pqd_reg  <= pqd_next;
            err_reg  <= err_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obytes_reg <= obytes_next;
        ocnt_reg   <= ocnt_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {{(OUT_TDATA_W - TRIPLE_W - COUNT_W){1'b0}}, ocnt_reg, obytes_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

`ifndef SYNTH
    a_err_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !olast_reg |-> !oerr_reg)
        else $error("error flag on a word that does not close the message");

    a_no_bytes_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && oerr_reg |-> ocnt_reg == CNT_NONE)
        else $error("bytes reported on a malformed message");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.last |=> pos_reg == POS_FIRST && !err_reg && !pqd_reg && !pat_reg)
        else $error("decoder state not cleared after message end");
`endif

endmodule
`default_nettype wire

>>> rtl/base64_stream_decoder_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// base64_stream_decoder_core
// Base64 character stream to decoded byte groups, one result word per input.
// ---------------------------------------------------------------------------
// path: an accepted character word passes the front register, the queue and
// the output register before its result word is valid
// throughput: one character word per cycle while m_tready is high; input and
// output stall apart through the queue and the output register
// reset: asynchronous active-low rst_n clears the queue, quad position,
// padding and error flags; the first word after reset starts a new message
module base64_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] byte0, [15:8] byte1, [23:16] byte2,
                                        // [25:24] byte_count, [31:26] zero
    output logic             m_tlast,   // msg_end
    output logic [0:0]       m_tuser    // [0] msg_error
);
    import b64d_pkg::*;

    logic       f_valid;
    logic       f_ready;
    b64d_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    b64d_item_t q_item;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire
